>>> design/mbrtu_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// function 04 master. No dependencies; every other design file but mbrtu_if refers to it.
`default_nettype none

package mbrtu_pkg;

	// Default values for the top-level parameters.
	localparam int MAX_REGISTERS_DEF = 125;
	localparam int TIMEOUT_WIDTH_DEF = 16;

	// Protocol constants.
	localparam logic [7:0]  FUNC_CODE = 8'h04;
	localparam logic [15:0] CRC_SEED  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Input request codes.
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_CRC       = 3'd1;
	localparam logic [2:0] ST_SLAVE     = 3'd2;
	localparam logic [2:0] ST_FUNC      = 3'd3;
	localparam logic [2:0] ST_COUNT     = 3'd4;
	localparam logic [2:0] ST_TIMEOUT   = 3'd5;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [1:0] REG_SLAVE_ID   = 2'd0;
	localparam logic [1:0] REG_START_REG  = 2'd1;
	localparam logic [1:0] REG_COUNT      = 2'd2;
	localparam logic [1:0] REG_TIMEOUT    = 2'd3;
	localparam int         PADDR_WIDTH    = 4;

	// One result word as it leaves the block.
	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  tx_byte;
		logic [6:0]  reg_index;
		logic [15:0] reg_value;
		logic [2:0]  status;
		logic        last;
	} rsp_word_t;

	// Live configuration shared by the request generator and the receiver.
	typedef struct packed {
		logic [7:0]  slave_addr;
		logic [15:0] first_reg;
		logic [6:0]  reg_count;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// Request generator status toward the top level.
	typedef struct packed {
		logic      busy;
		rsp_word_t word;
	} gen_out_t;

	// Reflected CRC-16 update over one byte, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/mbrtu_if.sv
// Channel interfaces for the Modbus RTU master: the input word channel and
// the result word channel. No dependencies.
`default_nettype none

// Input words: start, received byte or tick.
interface mbrtu_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	modport source(output valid, output req_type, output rx_byte, input ready);
	modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

// Result words: request bytes, provisional registers and final status.
interface mbrtu_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  tx_byte;
	logic [6:0]  reg_index;
	logic [15:0] reg_value;
	logic [2:0]  status;
	logic        last;
	modport source(output valid, output out_kind, output tx_byte, output reg_index,
		output reg_value, output status, output last, input ready);
	modport sink(input valid, input out_kind, input tx_byte, input reg_index,
		input reg_value, input status, input last, output ready);
endinterface

`default_nettype wire

>>> design/mbrtu_cfg.sv
// APB-style configuration registers of the Modbus RTU master.
// Depends on mbrtu_pkg for register indexes and the cfg_t type.
`default_nettype none

module mbrtu_cfg #(
	parameter int MAX_REGISTERS = mbrtu_pkg::MAX_REGISTERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mbrtu_pkg::PADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output mbrtu_pkg::cfg_t                        cfg
);

	localparam logic [6:0] MAX_CNT = 7'(MAX_REGISTERS);

	logic [7:0]  slave_addr_q;
	logic [15:0] start_reg_q;
	logic [6:0]  count_q;
	logic [15:0] timeout_q;
	logic        wr_en;
	logic [1:0]  wr_idx;
	logic [6:0]  count_wr;

	assign wr_en    = psel && penable && pwrite;
	assign wr_idx   = paddr[3:2];
	assign count_wr = (pwdata[6:0] > MAX_CNT) ? MAX_CNT : pwdata[6:0];

	// Register writes; the count saturates at the protocol limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			start_reg_q  <= 16'd0;
			count_q      <= 7'd45;
			timeout_q    <= 16'd100;
		end else if (wr_en) begin
			case (wr_idx)
				mbrtu_pkg::REG_SLAVE_ID:  slave_addr_q <= pwdata[7:0];
				mbrtu_pkg::REG_START_REG: start_reg_q  <= pwdata[15:0];
				mbrtu_pkg::REG_COUNT:     count_q      <= count_wr;
				mbrtu_pkg::REG_TIMEOUT:   timeout_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (wr_idx)
			mbrtu_pkg::REG_SLAVE_ID:  prdata = {24'd0, slave_addr_q};
			mbrtu_pkg::REG_START_REG: prdata = {16'd0, start_reg_q};
			mbrtu_pkg::REG_COUNT:     prdata = {25'd0, count_q};
			mbrtu_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg = '{slave_addr: slave_addr_q, first_reg: start_reg_q,
		reg_count: count_q, timeout_ticks: timeout_q};

endmodule

`default_nettype wire

>>> design/mbrtu_req_gen.sv
// Request generator: emits the eight request bytes of a function 04 query,
// one per advance, updating the CRC one byte per cycle while advance is high. Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_req_gen (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             advance,
	input  mbrtu_pkg::cfg_t       cfg,
	output mbrtu_pkg::gen_out_t   gen
);

	logic        busy_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  cur_byte;

	// Byte for the current position; the count high byte is always zero.
	always_comb begin
		case (idx_q)
			3'd0:    cur_byte = cfg.slave_addr;
			3'd1:    cur_byte = mbrtu_pkg::FUNC_CODE;
			3'd2:    cur_byte = cfg.first_reg[15:8];
			3'd3:    cur_byte = cfg.first_reg[7:0];
			3'd4:    cur_byte = 8'h00;
			3'd5:    cur_byte = {1'b0, cfg.reg_count};
			3'd6:    cur_byte = crc_q[7:0];
			default: cur_byte = crc_q[15:8];
		endcase
	end

	// Sequencer: load on start, step on each advance, stop after the eighth byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (advance && busy_q) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Running CRC over the first six bytes.
	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= mbrtu_pkg::CRC_SEED;
		end else if (advance && busy_q && idx_q < 3'd6) begin
			crc_q <= mbrtu_pkg::crc_byte(crc_q, cur_byte);
		end
	end

	assign gen.busy = busy_q;
	assign gen.word = '{out_kind: mbrtu_pkg::KIND_TX, tx_byte: cur_byte, reg_index: 7'd0,
		reg_value: 16'd0, status: mbrtu_pkg::ST_OK, last: (idx_q == 3'd7)};

endmodule

`default_nettype wire

>>> design/mbrtu_rx.sv
// Response receiver: applies one registered input word to the receive state
// and forms the result word it causes. Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_rx #(
	parameter int TIMEOUT_WIDTH = mbrtu_pkg::TIMEOUT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [1:0]       req_type,
	input  wire logic [7:0]       rx_byte,
	input  mbrtu_pkg::cfg_t       cfg,
	output logic                  has_result,
	output mbrtu_pkg::rsp_word_t  result
);

	localparam int CW = (TIMEOUT_WIDTH > 16) ? TIMEOUT_WIDTH : 16;
	localparam logic [TIMEOUT_WIDTH-1:0] IDLE_MAX = '1;

	typedef enum logic [1:0] {PH_IDLE, PH_RECV} phase_t;

	phase_t                   phase_q;
	logic [7:0]               pos_q;
	logic [15:0]              crc_q;
	logic [7:0]               held_hi_q;
	logic [7:0]               crc_lo_q;
	logic [2:0]               hdr_err_q;
	logic [TIMEOUT_WIDTH-1:0] idle_q;
	logic [6:0]               reg_cnt_q;

	logic [8:0]               total;
	logic [8:0]               pos1;
	logic [8:0]               pos2;
	logic                     recv;
	logic                     is_final;
	logic                     is_crc_lo;
	logic                     is_reg;
	logic [TIMEOUT_WIDTH-1:0] idle_next;
	logic                     timed_out;
	logic [2:0]               final_st;
	logic [2:0]               hdr_chk;

	// Response framing against the live register count.
	assign total     = 9'd5 + {1'b0, cfg.reg_count, 1'b0};
	assign pos1      = {1'b0, pos_q} + 9'd1;
	assign pos2      = {1'b0, pos_q} + 9'd2;
	assign recv      = (phase_q == PH_RECV);
	assign is_final  = (pos1 >= total);
	assign is_crc_lo = (pos2 == total);
	assign is_reg    = !is_final && !is_crc_lo && (pos_q >= 8'd3) && !pos_q[0];

	// Saturating idle counter and the timeout compare.
	assign idle_next = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign timed_out = (CW'(idle_next) >= CW'(cfg.timeout_ticks)) || (idle_next == IDLE_MAX);

	// CRC mismatch wins over any header error.
	assign final_st = ({rx_byte, crc_lo_q} != crc_q) ? mbrtu_pkg::ST_CRC : hdr_err_q;

	// Header check for the first three bytes.
	always_comb begin
		hdr_chk = mbrtu_pkg::ST_OK;
		case (pos_q)
			8'd0: if (rx_byte != cfg.slave_addr) hdr_chk = mbrtu_pkg::ST_SLAVE;
			8'd1: if (rx_byte != mbrtu_pkg::FUNC_CODE) hdr_chk = mbrtu_pkg::ST_FUNC;
			8'd2: if (rx_byte != {cfg.reg_count, 1'b0}) hdr_chk = mbrtu_pkg::ST_COUNT;
			default: hdr_chk = mbrtu_pkg::ST_OK;
		endcase
	end

	// Result selection.
	always_comb begin
		has_result = 1'b0;
		result = '{out_kind: mbrtu_pkg::KIND_STATUS, tx_byte: 8'd0, reg_index: 7'd0,
			reg_value: 16'd0, status: mbrtu_pkg::ST_OK, last: 1'b1};
		case (req_type)
			mbrtu_pkg::REQ_BYTE: begin
				if (recv && is_final) begin
					has_result    = 1'b1;
					result.status = final_st;
				end else if (recv && is_reg) begin
					has_result       = 1'b1;
					result.out_kind  = mbrtu_pkg::KIND_REG;
					result.reg_index = reg_cnt_q;
					result.reg_value = {held_hi_q, rx_byte};
					result.last      = 1'b0;
				end
			end
			mbrtu_pkg::REQ_TICK: begin
				if (recv && timed_out) begin
					has_result    = 1'b1;
					result.status = mbrtu_pkg::ST_TIMEOUT;
				end
			end
			default: has_result = 1'b0;
		endcase
	end

	// Receive state and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= 8'd0;
			crc_q     <= mbrtu_pkg::CRC_SEED;
			held_hi_q <= 8'd0;
			crc_lo_q  <= 8'd0;
			hdr_err_q <= mbrtu_pkg::ST_OK;
			idle_q    <= '0;
			reg_cnt_q <= 7'd0;
		end else if (fire) begin
			case (req_type)
				mbrtu_pkg::REQ_START: begin
					phase_q   <= PH_RECV;
					pos_q     <= 8'd0;
					crc_q     <= mbrtu_pkg::CRC_SEED;
					held_hi_q <= 8'd0;
					crc_lo_q  <= 8'd0;
					hdr_err_q <= mbrtu_pkg::ST_OK;
					idle_q    <= '0;
					reg_cnt_q <= 7'd0;
				end
				mbrtu_pkg::REQ_TICK: begin
					if (recv) begin
						idle_q <= idle_next;
						if (timed_out) begin
							phase_q <= PH_IDLE;
						end
					end
				end
				mbrtu_pkg::REQ_BYTE: begin
					if (recv) begin
						idle_q <= '0;
						if (is_final) begin
							phase_q <= PH_IDLE;
							pos_q   <= 8'd0;
						end else begin
							pos_q <= pos1[7:0];
							if (is_crc_lo) begin
								crc_lo_q <= rx_byte;
							end else begin
								crc_q <= mbrtu_pkg::crc_byte(crc_q, rx_byte);
								if (pos_q < 8'd3) begin
									if (hdr_err_q == mbrtu_pkg::ST_OK) begin
										hdr_err_q <= hdr_chk;
									end
								end else if (pos_q[0]) begin
									held_hi_q <= rx_byte;
								end else begin
									reg_cnt_q <= reg_cnt_q + 7'd1;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/modbus_rtu_read_input_master.sv
// Top level of the Modbus RTU function 04 master: input register, request
// generator, receiver and output register. Depends on mbrtu_pkg, mbrtu_if,
// mbrtu_cfg, mbrtu_req_gen and mbrtu_rx.
`default_nettype none

// Each input word is taken into an input register and handled there;
// received bytes and ticks sustain one word per clock when the result side
// keeps up. A start word hands its query to the request generator, which
// sends the eight request bytes, computing the request CRC one byte per cycle
// while the result side keeps up; words behind a start wait in the input
// register until the last request byte has been sent. All results leave
// through a single output register that refills in the cycle it is taken, so
// the result channel sets the pace when it stalls. There is no clearing pass
// after reset.
module modbus_rtu_read_input_master #(
	parameter int MAX_REGISTERS = mbrtu_pkg::MAX_REGISTERS_DEF,
	parameter int TIMEOUT_WIDTH = mbrtu_pkg::TIMEOUT_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mbrtu_pkg::PADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	mbrtu_cmd_if.sink                              cmd,
	mbrtu_rsp_if.source                            rsp
);

	mbrtu_pkg::cfg_t      cfg;
	mbrtu_pkg::gen_out_t  gen;
	mbrtu_pkg::rsp_word_t rx_word;
	mbrtu_pkg::rsp_word_t out_q;

	logic       valid_s1;
	logic [1:0] req_s1;
	logic [7:0] rx_s1;
	logic       rx_has;
	logic       fire_s1;
	logic       slot_free;
	logic       out_valid_q;
	logic       gen_start;

	assign pready    = 1'b1;
	assign slot_free = !out_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && !gen.busy && (!rx_has || slot_free);
	assign gen_start = fire_s1 && (req_s1 == mbrtu_pkg::REQ_START);
	assign cmd.ready = !valid_s1 || fire_s1;

	mbrtu_cfg #(
		.MAX_REGISTERS(MAX_REGISTERS)
	) u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	mbrtu_req_gen u_gen (
		.clk(clk), .arst_n(arst_n), .start(gen_start), .advance(slot_free),
		.cfg(cfg), .gen(gen)
	);

	mbrtu_rx #(
		.TIMEOUT_WIDTH(TIMEOUT_WIDTH)
	) u_rx (
		.clk(clk), .arst_n(arst_n), .fire(fire_s1), .req_type(req_s1), .rx_byte(rx_s1),
		.cfg(cfg), .has_result(rx_has), .result(rx_word)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			req_s1 <= cmd.req_type;
			rx_s1  <= cmd.rx_byte;
		end
	end

	// Output register: request bytes take priority while the generator runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= gen.busy || (fire_s1 && rx_has);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_q <= gen.busy ? gen.word : rx_word;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_kind  = out_q.out_kind;
	assign rsp.tx_byte   = out_q.tx_byte;
	assign rsp.reg_index = out_q.reg_index;
	assign rsp.reg_value = out_q.reg_value;
	assign rsp.status    = out_q.status;
	assign rsp.last      = out_q.last;

endmodule

`default_nettype wire

>>> design/mbrtu_checker.sv
// Port-level checker for the Modbus RTU master and its bind to the top level.
// Depends on mbrtu_pkg for result kinds and status codes.
`default_nettype none

module mbrtu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  out_kind,
	input wire logic [7:0]  tx_byte,
	input wire logic [2:0]  status,
	input wire logic        last
);

	// A stalled result word keeps its kind and marker.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_kind) && $stable(last))
		else $error("result word changed while stalled");

	// Status words always close a burst and carry a defined code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_kind == mbrtu_pkg::KIND_STATUS |-> last && status <= mbrtu_pkg::ST_TIMEOUT)
		else $error("bad status word");

	// Register words never close a burst and carry no status or request byte.
	a_reg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_kind == mbrtu_pkg::KIND_REG |-> !last && status == mbrtu_pkg::ST_OK
		&& tx_byte == 8'd0)
		else $error("bad register word");

	// Only the three defined kinds appear.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> out_kind == mbrtu_pkg::KIND_TX || out_kind == mbrtu_pkg::KIND_REG
		|| out_kind == mbrtu_pkg::KIND_STATUS)
		else $error("undefined result kind");

endmodule

bind modbus_rtu_read_input_master mbrtu_checker u_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.out_kind(rsp.out_kind), .tx_byte(rsp.tx_byte), .status(rsp.status), .last(rsp.last)
);

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the Modbus RTU function 04 master: queues start, byte and tick words,
// follows the master's receive state to work out every result word, and checks them.
// Depends on mbrtu_pkg, mbrtu_if and modbus_rtu_read_input_master.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0]  REQ_UNUSED    = 2'd3;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
	localparam logic [6:0]  COUNT_MAX     = 7'(mbrtu_pkg::MAX_REGISTERS_DEF);
	localparam int          HOLD_CYCLES   = 300;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_WORDS   = 20;
	localparam int          CUT_SPAN      = 24;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] data;
	} link_word_t;

	typedef enum logic {LINK_IDLE, LINK_RECV} link_phase_t;

	typedef enum int {
		POLL_GOOD, POLL_BAD_SLAVE, POLL_BAD_FUNC, POLL_BAD_COUNT,
		POLL_BAD_HEADER, POLL_BAD_CRC, POLL_CUT
	} poll_kind_t;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [mbrtu_pkg::PADDR_WIDTH-1:0] paddr;
	logic [31:0]                       pwdata;
	logic [31:0]                       prdata;
	logic                              pready;

	mbrtu_cmd_if cmd ();
	mbrtu_rsp_if rsp ();

	modbus_rtu_read_input_master u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd),
		.rsp     (rsp)
	);

	// Configuration as last written.
	logic [7:0]  cfg_slave;
	logic [15:0] cfg_start;
	logic [6:0]  cfg_count;
	logic [15:0] cfg_timeout;

	// Receive state of the master as the testbench follows it.
	link_phase_t link_phase;
	logic [7:0]  rx_pos;
	logic [15:0] rx_crc;
	logic [7:0]  hi_byte;
	logic [7:0]  crc_lo;
	logic [2:0]  hdr_err;
	logic [15:0] idle_cnt;
	logic [6:0]  reg_num;

	link_word_t            link_inputs[$];
	mbrtu_pkg::rsp_word_t  owed_words[$];
	int                    sent_words;
	int                    mismatches;
	int                    stalled_cycles;
	bit                    cmd_taken;
	bit                    quiet_mode;
	int                    hold_asked;
	int                    hold_served;
	int                    hold_left;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Reflected CRC-16 over one byte, LSB first.
	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
		logic [15:0] acc;
		acc = crc ^ {8'h00, data};
		repeat (8) begin
			acc = acc[0] ? ({1'b0, acc[15:1]} ^ mbrtu_pkg::CRC_POLY) : {1'b0, acc[15:1]};
		end
		return acc;
	endfunction

	function automatic void owe_word(logic [1:0] kind, logic [7:0] tx, logic [6:0] idx,
		logic [15:0] val, logic [2:0] st, logic is_last);
		owed_words.push_back('{out_kind: kind, tx_byte: tx, reg_index: idx,
			reg_value: val, status: st, last: is_last});
	endfunction

	function automatic void restart_receive();
		rx_pos   = '0;
		rx_crc   = mbrtu_pkg::CRC_SEED;
		hi_byte  = '0;
		crc_lo   = '0;
		hdr_err  = mbrtu_pkg::ST_OK;
		idle_cnt = '0;
		reg_num  = '0;
	endfunction

	// Steps the followed state by one accepted input word and queues the words it owes.
	task automatic advance_master(input logic [1:0] req, input logic [7:0] rx);
		logic [7:0]  frame [8];
		logic [15:0] crc;
		int unsigned total;
		int unsigned pos;
		int          i;
		total = 5 + 2 * cfg_count;
		pos   = rx_pos;
		case (req)
			mbrtu_pkg::REQ_START: begin
				frame[0] = cfg_slave;
				frame[1] = mbrtu_pkg::FUNC_CODE;
				frame[2] = cfg_start[15:8];
				frame[3] = cfg_start[7:0];
				frame[4] = 8'h00;
				frame[5] = {1'b0, cfg_count};
				crc = mbrtu_pkg::CRC_SEED;
				for (i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
				frame[6] = crc[7:0];
				frame[7] = crc[15:8];
				for (i = 0; i < 8; i++)
					owe_word(mbrtu_pkg::KIND_TX, frame[i], '0, '0, mbrtu_pkg::ST_OK, i == 7);
				restart_receive();
				link_phase = LINK_RECV;
			end
			mbrtu_pkg::REQ_TICK: if (link_phase == LINK_RECV) begin
				if (idle_cnt != IDLE_MAX) idle_cnt++;
				if (idle_cnt >= cfg_timeout || idle_cnt == IDLE_MAX) begin
					owe_word(mbrtu_pkg::KIND_STATUS, '0, '0, '0, mbrtu_pkg::ST_TIMEOUT, 1'b1);
					link_phase = LINK_IDLE;
				end
			end
			mbrtu_pkg::REQ_BYTE: if (link_phase == LINK_RECV) begin
				idle_cnt = '0;
				if (pos + 1 >= total) begin
					// Final CRC byte: a CRC mismatch outranks any header error.
					owe_word(mbrtu_pkg::KIND_STATUS, '0, '0, '0,
						({rx, crc_lo} != rx_crc) ? mbrtu_pkg::ST_CRC : hdr_err, 1'b1);
					link_phase = LINK_IDLE;
					rx_pos = '0;
				end else begin
					rx_pos = 8'(pos + 1);
					if (pos + 2 == total) begin
						crc_lo = rx;
					end else begin
						rx_crc = crc16_step(rx_crc, rx);
						if (pos == 0) begin
							if (rx != cfg_slave && hdr_err == mbrtu_pkg::ST_OK)
								hdr_err = mbrtu_pkg::ST_SLAVE;
						end else if (pos == 1) begin
							if (rx != mbrtu_pkg::FUNC_CODE && hdr_err == mbrtu_pkg::ST_OK)
								hdr_err = mbrtu_pkg::ST_FUNC;
						end else if (pos == 2) begin
							if (rx != 8'(2 * cfg_count) && hdr_err == mbrtu_pkg::ST_OK)
								hdr_err = mbrtu_pkg::ST_COUNT;
						end else if (((pos - 3) & 1) == 0) begin
							hi_byte = rx;
						end else begin
							// Registers go out even after a header error.
							owe_word(mbrtu_pkg::KIND_REG, '0, reg_num, {hi_byte, rx},
								mbrtu_pkg::ST_OK, 1'b0);
							reg_num++;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Monitor: checks result words, follows accepted input words, and watches for a hang.
	always @(posedge clk or negedge arst_n) begin
		mbrtu_pkg::rsp_word_t due;
		if (!arst_n) begin
			cmd_taken      <= 1'b0;
			stalled_cycles <= 0;
			mismatches     = 0;
			link_phase     = LINK_IDLE;
			restart_receive();
		end else begin
			cmd_taken <= cmd.valid && cmd.ready;
			if (rsp.valid && rsp.ready) begin
				if (owed_words.size() == 0) begin
					$error("result word of kind %0d with none due", rsp.out_kind);
					mismatches++;
				end else begin
					due = owed_words.pop_front();
					compare_field("out_kind", due.out_kind, rsp.out_kind);
					compare_field("tx_byte", due.tx_byte, rsp.tx_byte);
					compare_field("reg_index", due.reg_index, rsp.reg_index);
					compare_field("reg_value", due.reg_value, rsp.reg_value);
					compare_field("status", due.status, rsp.status);
					compare_field("last", due.last, rsp.last);
				end
			end
			if (cmd.valid && cmd.ready) advance_master(cmd.req_type, cmd.rx_byte);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) stalled_cycles <= 0;
			else stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Driver: holds a word until it is taken, then offers the next one after a random gap.
	always @(negedge clk) begin
		bit offer;
		if (!arst_n) begin
			cmd.valid    <= 1'b0;
			cmd.req_type <= mbrtu_pkg::REQ_TICK;
			cmd.rx_byte  <= '0;
		end else begin
			if (cmd_taken) link_inputs.delete(0);
			offer = cmd.valid && !cmd_taken;
			if (!offer && link_inputs.size() != 0)
				offer = quiet_mode || $urandom_range(0, 99) >= 30;
			cmd.valid <= offer;
			if (offer) begin
				cmd.req_type <= link_inputs[0].req;
				cmd.rx_byte  <= link_inputs[0].data;
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready   <= 1'b0;
			hold_served <= 0;
			hold_left   <= 0;
		end else if (hold_left != 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			rsp.ready   <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
		end else begin
			rsp.ready <= quiet_mode || $urandom_range(0, 99) >= 30;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			mbrtu_pkg::REG_SLAVE_ID:  cfg_slave   = value[7:0];
			mbrtu_pkg::REG_START_REG: cfg_start   = value[15:0];
			mbrtu_pkg::REG_COUNT:     cfg_count   = (value[6:0] > COUNT_MAX) ? COUNT_MAX : value[6:0];
			mbrtu_pkg::REG_TIMEOUT:   cfg_timeout = value[15:0];
			default: ;
		endcase
	endtask

	task automatic send(logic [1:0] req, logic [7:0] data);
		link_inputs.push_back('{req: req, data: data});
		sent_words++;
	endtask

	// Words that an idle master drops; they do not count toward the phase size.
	task automatic send_noise();
		case ($urandom_range(0, 2))
			0:       link_inputs.push_back('{req: mbrtu_pkg::REQ_BYTE, data: 8'($urandom)});
			1:       link_inputs.push_back('{req: mbrtu_pkg::REQ_TICK, data: 8'($urandom)});
			default: link_inputs.push_back('{req: REQ_UNUSED, data: 8'($urandom)});
		endcase
	endtask

	function automatic void append_crc(ref logic [7:0] frame[$]);
		logic [15:0] crc;
		int          i;
		crc = mbrtu_pkg::CRC_SEED;
		for (i = 0; i < frame.size(); i++) crc = crc16_step(crc, frame[i]);
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
	endfunction

	task automatic send_bytes(logic [7:0] frame[$]);
		int i;
		for (i = 0; i < frame.size(); i++) send(mbrtu_pkg::REQ_BYTE, frame[i]);
	endtask

	// One query and a slave response shaped by the poll kind, with ticks between bytes.
	task automatic send_poll(poll_kind_t kind);
		logic [7:0]  frame[$];
		int unsigned cut;
		int unsigned ticks;
		int unsigned at;
		int unsigned i;
		send(mbrtu_pkg::REQ_START, 8'($urandom));
		frame.push_back(cfg_slave);
		frame.push_back(mbrtu_pkg::FUNC_CODE);
		frame.push_back(8'(2 * cfg_count));
		repeat (2 * cfg_count) frame.push_back(8'($urandom));
		if (kind == POLL_BAD_SLAVE || kind == POLL_BAD_HEADER)
			frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
		if (kind == POLL_BAD_FUNC || kind == POLL_BAD_HEADER)
			frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
		if (kind == POLL_BAD_COUNT || kind == POLL_BAD_HEADER)
			frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
		append_crc(frame);
		if (kind == POLL_BAD_CRC) begin
			at = $urandom_range(0, frame.size() - 1);
			frame[at] = frame[at] ^ 8'($urandom_range(1, 255));
		end
		cut = frame.size();
		if (kind == POLL_CUT) begin
			cut = $urandom_range(0, frame.size() - 1);
			// Long responses are cut early so the run stays short.
			if (cut > CUT_SPAN) cut = $urandom_range(0, CUT_SPAN);
		end
		ticks = 0;
		for (i = 0; i < cut; i++) begin
			// Ticks stay short of the timeout so the response survives.
			while (ticks + 1 < cfg_timeout && $urandom_range(0, 7) == 0) begin
				send(mbrtu_pkg::REQ_TICK, 8'($urandom));
				ticks++;
			end
			if ($urandom_range(0, 19) == 0)
				link_inputs.push_back('{req: REQ_UNUSED, data: 8'($urandom)});
			send(mbrtu_pkg::REQ_BYTE, frame[i]);
			ticks = 0;
		end
		// A cut response runs into the timeout when that is short; else the next start drops it.
		if (kind == POLL_CUT && cfg_timeout <= 40)
			repeat ((cfg_timeout == 0) ? 1 : cfg_timeout) send(mbrtu_pkg::REQ_TICK, 8'($urandom));
	endtask

	// Lets every queued word go in and every owed word come out, then lets the design settle.
	task automatic wait_for_quiet();
		do @(posedge clk); while (link_inputs.size() != 0);
		do @(negedge clk); while (owed_words.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [7:0]  frame[$];
		int unsigned r;
		int          step_no;
		int          goal;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		cfg_slave    = 8'd1;
		cfg_start    = 16'd0;
		cfg_count    = 7'd45;
		cfg_timeout  = 16'd100;
		sent_words   = 0;
		quiet_mode   = 1'b0;
		hold_asked   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes of every register: zero count and a timeout on the first tick.
		write_reg(mbrtu_pkg::REG_SLAVE_ID, 32'h00);
		write_reg(mbrtu_pkg::REG_START_REG, 32'hFFFF);
		write_reg(mbrtu_pkg::REG_COUNT, 32'd0);
		write_reg(mbrtu_pkg::REG_TIMEOUT, 32'd0);
		@(posedge clk);
		// An idle master drops bytes, ticks and the unused code.
		send(mbrtu_pkg::REQ_BYTE, 8'hFF);
		send(mbrtu_pkg::REQ_TICK, 8'h00);
		send(REQ_UNUSED, 8'hFF);
		send(mbrtu_pkg::REQ_START, 8'h00);
		send(mbrtu_pkg::REQ_TICK, 8'hFF);
		wait_for_quiet();

		write_reg(mbrtu_pkg::REG_SLAVE_ID, 32'hFF);
		write_reg(mbrtu_pkg::REG_COUNT, 32'd1);
		write_reg(mbrtu_pkg::REG_TIMEOUT, 32'd2);
		@(posedge clk);
		// Clean one-register response.
		send(mbrtu_pkg::REQ_START, 8'hFF);
		frame = '{8'hFF, mbrtu_pkg::FUNC_CODE, 8'h02, 8'hFF, 8'h00};
		append_crc(frame);
		send_bytes(frame);
		// A second start abandons a half-received response without a status.
		send(mbrtu_pkg::REQ_START, 8'h00);
		send(mbrtu_pkg::REQ_BYTE, 8'h00);
		send(mbrtu_pkg::REQ_BYTE, 8'h03);
		send(mbrtu_pkg::REQ_START, 8'h00);
		// Wrong byte count with a good CRC still emits its register.
		frame = '{8'hFF, mbrtu_pkg::FUNC_CODE, 8'h00, 8'h00, 8'hFF};
		append_crc(frame);
		send_bytes(frame);
		wait_for_quiet();

		// Random phases, each under its own configuration.
		for (step_no = 0; step_no < RANDOM_PHASES; step_no++) begin
			case ($urandom_range(0, 2))
				0:       write_reg(mbrtu_pkg::REG_SLAVE_ID, 32'h00);
				1:       write_reg(mbrtu_pkg::REG_SLAVE_ID, 32'hFF);
				default: write_reg(mbrtu_pkg::REG_SLAVE_ID, $urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 2))
				0:       write_reg(mbrtu_pkg::REG_START_REG, 32'h0000);
				1:       write_reg(mbrtu_pkg::REG_START_REG, 32'hFFFF);
				default: write_reg(mbrtu_pkg::REG_START_REG, $urandom_range(0, 65535));
			endcase
			// Above the protocol limit the count saturates to the full 125 registers;
			// those long responses are cut short.
			if (step_no == 5) write_reg(mbrtu_pkg::REG_COUNT, 32'd127);
			else write_reg(mbrtu_pkg::REG_COUNT, $urandom_range(0, 4));
			if (step_no == 3) write_reg(mbrtu_pkg::REG_TIMEOUT, 32'hFFFF);
			else if (step_no == 1) write_reg(mbrtu_pkg::REG_TIMEOUT, 32'd1);
			else write_reg(mbrtu_pkg::REG_TIMEOUT, $urandom_range(2, 12));
			@(posedge clk);
			quiet_mode = (step_no == 0);
			if (step_no == 2) hold_asked++;
			goal = sent_words + PHASE_WORDS;
			while (sent_words < goal) begin
				r = $urandom_range(0, 9);
				if (step_no == 5) send_poll(POLL_CUT);
				else send_poll((r < 4) ? POLL_GOOD : poll_kind_t'(r - 3));
				if ($urandom_range(0, 4) == 0) send_noise();
			end
			wait_for_quiet();
		end

		// Shrinking the count under a partial response makes the next byte the final one.
		write_reg(mbrtu_pkg::REG_COUNT, 32'd3);
		write_reg(mbrtu_pkg::REG_TIMEOUT, 32'd100);
		@(posedge clk);
		send(mbrtu_pkg::REQ_START, 8'($urandom));
		repeat (6) send(mbrtu_pkg::REQ_BYTE, 8'($urandom));
		wait_for_quiet();
		write_reg(mbrtu_pkg::REG_COUNT, 32'd0);
		@(posedge clk);
		send(mbrtu_pkg::REQ_BYTE, 8'($urandom));
		send_poll(POLL_GOOD);
		wait_for_quiet();

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
design/mbrtu_pkg.sv
design/mbrtu_if.sv
design/mbrtu_cfg.sv
design/mbrtu_req_gen.sv
design/mbrtu_rx.sv
design/modbus_rtu_read_input_master.sv
design/mbrtu_checker.sv
dv/tb_top.sv
